// ----- sv/cgd_pkg.sv -----
package cgd_pkg;

   localparam int unsigned GRAD_WIDTH = 24;
   localparam int unsigned SUM_WIDTH  = 64;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EMIT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [GRAD_WIDTH-1:0]  gradient;
      logic                          restart;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [GRAD_WIDTH-1:0]  direction;
      logic [GRAD_WIDTH-1:0]         beta;
      logic                          beta_valid;
      logic                          zero_norm;
      logic                          end_of_vector;
   } rsp_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_LD_MUL,
      BACK_LD_ACC,
      BACK_LD_END,
      BACK_DIV,
      BACK_EM_MUL,
      BACK_EM_OUT
   } back_state_type;

   function automatic logic signed [SUM_WIDTH-1:0] sat_add64(
      input logic signed [SUM_WIDTH-1:0] x,
      input logic signed [SUM_WIDTH-1:0] y
   );
      logic signed [SUM_WIDTH-1:0] s;
      s = x + y;
      if (!x[SUM_WIDTH-1] && !y[SUM_WIDTH-1] && s[SUM_WIDTH-1])
         return {1'b0, {(SUM_WIDTH-1){1'b1}}};
      if (x[SUM_WIDTH-1] && y[SUM_WIDTH-1] && !s[SUM_WIDTH-1])
         return {1'b1, {(SUM_WIDTH-1){1'b0}}};
      return s;
   endfunction

endpackage

// ----- sv/cgd_front.sv -----
// input fifo: decouples the accept side from the back end
module cgd_front
   import cgd_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type push_data,
   output logic    avail,
   input  logic    take,
   output req_type head
);

   localparam int unsigned AW = $clog2(DEPTH);

   req_type           mem [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign avail   = (cnt_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = take && avail;
   assign head    = mem[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_data;
   end

endmodule

// ----- sv/cgd_divider.sv -----
// restoring divider, one quotient bit per cycle, QW-bit dividend by 64-bit divisor
module cgd_divider
   import cgd_pkg::*;
#(
   parameter int unsigned QW = 80
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [QW-1:0]        numer,
   input  logic [SUM_WIDTH-1:0] denom,
   output logic                 done,
   output logic [QW-1:0]        quot
);

   localparam int unsigned CW = $clog2(QW + 1);

   logic [QW-1:0]        q_ff, q_in;
   logic [SUM_WIDTH-1:0] r_ff, r_in, d_ff, d_in;
   logic [CW-1:0]        n_ff, n_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [SUM_WIDTH:0]   trial;

   assign trial = {r_ff, q_ff[QW-1]};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = numer; r_in = '0; d_in = denom;
         n_in = CW'(QW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = SUM_WIDTH'(trial - {1'b0, d_ff});
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            r_in = trial[SUM_WIDTH-1:0];
            q_in = {q_ff[QW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- sv/cgd_back.sv -----
// executes loads and emits; owns the vector stores and the sums
module cgd_back
   import cgd_pkg::*;
#(
   parameter int unsigned MAX_LEN   = 4096,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    avail,
   output logic    take,
   input  req_type head,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam int unsigned IW = $clog2(MAX_LEN);
   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam int unsigned DW = GRAD_WIDTH;
   localparam int unsigned QW = SUM_WIDTH + FRAC_BITS;
   localparam int unsigned PW = 2*DW + 1;
   localparam logic [QW-1:0] BETA_LIM = QW'({DW{1'b1}});
   localparam logic signed [PW:0] RES_MAX = (PW+1)'((64'sd1 <<< (DW - 1)) - 64'sd1);
   localparam logic signed [PW:0] RES_MIN = -RES_MAX - 1;

   // previous and direction stores are zeroed by a clearing pass over all MAX_LEN
   // entries after reset; the current store is only read where written
   logic [DW-1:0] cur_mem  [MAX_LEN];
   logic [DW-1:0] prev_mem [MAX_LEN];
   logic [DW-1:0] dir_mem  [MAX_LEN];

   back_state_type st_ff, st_in;

   logic                        clr_ff;
   logic [IW-1:0]               clr_idx_ff;
   logic signed [SUM_WIDTH-1:0] scc_ff, scp_ff, spp_ff;
   logic [DW-1:0]               beta_ff;
   logic [LW-1:0]               lidx_ff, eidx_ff, vlen_ff;
   logic                        rs_ff;
   logic signed [DW-1:0]        g_ff, p_rd_ff, cur_rd_ff, dir_rd_ff;
   logic                        ld_last_ff, ld_store_ff;
   logic                        out_v_ff;
   rsp_type                     out_ff;
   logic signed [2*DW-1:0]      gg_ff, gp_ff, pp_ff;
   logic signed [PW-1:0]        prod_ff;

   logic                        div_start, div_done;
   logic [SUM_WIDTH-1:0]        numer;
   logic [QW-1:0]               dividend, quot;

   logic                        is_load, is_emit, emit_ok, new_vec, ld_store;
   logic                        beta_done, out_set;
   logic [LW-1:0]               lidx_eff, eidx_nx;
   logic [IW-1:0]               lix, eix;
   logic [DW-1:0]               beta_nx, em_res;
   logic signed [PW-1:0]        em_term;
   logic signed [PW:0]          em_sum;
   rsp_type                     out_nx;

   assign is_load  = head.cmd == CMD_LOAD;
   assign is_emit  = head.cmd == CMD_EMIT;
   assign emit_ok  = (vlen_ff != '0) && (eidx_ff < vlen_ff);
   // a load while a complete vector is held starts a new one
   assign new_vec  = (vlen_ff != '0);
   assign lidx_eff = new_vec ? '0 : lidx_ff;
   // loads past the store size are neither stored nor summed
   assign ld_store = (lidx_eff < LW'(MAX_LEN));
   assign lix      = lidx_eff[IW-1:0];
   assign eix      = eidx_ff[IW-1:0];
   assign eidx_nx  = eidx_ff + 1'b1;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BACK_IDLE:   if (take) st_in = is_load ? BACK_LD_MUL :
                                        (emit_ok ? BACK_EM_MUL : BACK_IDLE);
         BACK_LD_MUL: st_in = BACK_LD_ACC;
         BACK_LD_ACC: st_in = ld_last_ff ? BACK_LD_END : BACK_IDLE;
         BACK_LD_END: st_in = div_start ? BACK_DIV : BACK_IDLE;
         BACK_DIV:    if (div_done) st_in = BACK_IDLE;
         BACK_EM_MUL: st_in = BACK_EM_OUT;
         BACK_EM_OUT: st_in = BACK_IDLE;
         default:     st_in = BACK_IDLE;
      endcase
   end

   // state outputs: an item is taken only while the result register is empty
   always_comb begin
      take      = 1'b0;
      div_start = 1'b0;
      unique case (st_ff)
         BACK_IDLE:   take = !clr_ff && avail && !out_v_ff;
         BACK_LD_END: div_start = !rs_ff && (spp_ff != '0) && (scc_ff > scp_ff);
         default:     ;
      endcase
   end

   // numerator a - b is positive here, so the wrapped difference is exact
   assign numer    = SUM_WIDTH'(scc_ff - scp_ff);
   assign dividend = QW'(numer) << FRAC_BITS;

   cgd_divider #(.QW (QW)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .numer (dividend), .denom ($unsigned(spp_ff)),
      .done (div_done), .quot (quot)
   );

   assign beta_done = (st_ff == BACK_LD_END && !div_start) || (st_ff == BACK_DIV && div_done);
   assign out_set   = beta_done || (st_ff == BACK_EM_OUT);

   always_comb begin
      if (st_ff != BACK_DIV) beta_nx = '0;
      else if (quot > BETA_LIM) beta_nx = '1;
      else beta_nx = quot[DW-1:0];
   end

   // direction: g plus beta*d scaled back with floor, saturated
   always_comb begin
      em_term = prod_ff >>> FRAC_BITS;
      em_sum  = (PW+1)'(cur_rd_ff) + (PW+1)'(em_term);
      if (em_sum > RES_MAX) em_res = RES_MAX[DW-1:0];
      else if (em_sum < RES_MIN) em_res = RES_MIN[DW-1:0];
      else em_res = em_sum[DW-1:0];
   end

   always_comb begin
      out_nx = '0;
      if (st_ff == BACK_EM_OUT) begin
         out_nx.direction     = em_res;
         out_nx.beta          = beta_ff;
         out_nx.end_of_vector = (eidx_nx == vlen_ff);
      end else begin
         out_nx.beta       = beta_nx;
         out_nx.beta_valid = 1'b1;
         out_nx.zero_norm  = (st_ff == BACK_LD_END) && !rs_ff && (spp_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BACK_IDLE; clr_ff <= 1'b1; clr_idx_ff <= '0;
         scc_ff <= '0; scp_ff <= '0; spp_ff <= '0;
         beta_ff <= '0; lidx_ff <= '0; eidx_ff <= '0; vlen_ff <= '0;
         rs_ff <= 1'b0; out_v_ff <= 1'b0; out_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == IW'(MAX_LEN-1)) clr_ff <= 1'b0;
         end
         if (out_set) begin
            out_v_ff <= 1'b1;
            out_ff   <= out_nx;
         end else if (out_v_ff && out_ready) begin
            out_v_ff <= 1'b0;
         end
         if (take && is_load) begin
            if (new_vec) begin
               scc_ff <= '0; scp_ff <= '0; spp_ff <= '0;
               eidx_ff <= '0; vlen_ff <= '0;
            end
            rs_ff   <= (rs_ff && !new_vec) || head.restart;
            lidx_ff <= lidx_eff + LW'(ld_store);
         end else if (st_ff == BACK_LD_ACC && ld_store_ff) begin
            scc_ff <= sat_add64(scc_ff, SUM_WIDTH'(gg_ff));
            scp_ff <= sat_add64(scp_ff, SUM_WIDTH'(gp_ff));
            spp_ff <= sat_add64(spp_ff, SUM_WIDTH'(pp_ff));
         end else if (beta_done) begin
            beta_ff <= beta_nx;
            vlen_ff <= lidx_ff;
            eidx_ff <= '0;
         end else if (st_ff == BACK_EM_OUT) begin
            eidx_ff <= eidx_nx;
         end
      end
   end

   // load item and products, one pipeline step each
   always_ff @(posedge clock) begin
      if (take) begin
         g_ff        <= head.gradient;
         ld_last_ff  <= head.last;
         ld_store_ff <= ld_store;
      end
      gg_ff   <= g_ff * g_ff;
      gp_ff   <= g_ff * p_rd_ff;
      pp_ff   <= p_rd_ff * p_rd_ff;
      prod_ff <= $signed({1'b0, beta_ff}) * dir_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (take && is_load && ld_store) cur_mem[lix] <= head.gradient;
      if (take && is_emit && emit_ok) cur_rd_ff <= cur_mem[eix];
   end

   always_ff @(posedge clock) begin
      if (clr_ff) prev_mem[clr_idx_ff] <= '0;
      else if (st_ff == BACK_EM_OUT) prev_mem[eix] <= cur_rd_ff;
      if (take && is_load && ld_store) p_rd_ff <= prev_mem[lix];
   end

   always_ff @(posedge clock) begin
      if (clr_ff) dir_mem[clr_idx_ff] <= '0;
      else if (st_ff == BACK_EM_OUT) dir_mem[eix] <= em_res;
      if (take && is_emit && emit_ok) dir_rd_ff <= dir_mem[eix];
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

// ----- sv/conjugate_gradient_direction_unit.sv -----
// conjugate gradient direction unit (polak-ribiere plus). both sides look like
// a queue: a request transfers on req_push with req_full low, a result transfers
// on rsp_pop with rsp_empty low. loads (cmd 0) stream a gradient vector and build
// |g|^2, g.prev and |prev|^2; the load marked last reports beta = (a-b)/c,
// clamped to zero and saturated, or zero with zero_norm when |prev|^2 is zero and
// no restart was seen. emits (cmd 1) then give cur + beta*dir in index order.
// items are handled one at a time behind a 4-deep input fifo: a load that is not
// last goes through mul and acc states, an emit through mul and out states, an
// emit with nothing pending is dropped, a last load adds an end state and the
// bit-serial divide when it runs; no new item is taken while a result waits to be popped.
// after reset a clearing pass over all MAX_LEN entries zeroes the previous and
// direction stores; the fifo fills and req_full rises until it is done
module conjugate_gradient_direction_unit
   import cgd_pkg::*;
#(
   parameter int unsigned MAX_LEN   = 4096,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);
   logic avail, take, ov;
   req_type head;

   // front: accepts request transfers into a short fifo
   cgd_front u_front (
      .clock, .reset, .push (req_push), .full (req_full), .push_data (req_data),
      .avail, .take, .head
   );
   // back: runs loads, the beta divide and emits, holds the result register
   cgd_back #(.MAX_LEN (MAX_LEN), .FRAC_BITS (FRAC_BITS)) u_back (
      .clock, .reset, .avail, .take, .head,
      .out_valid (ov), .out_ready (rsp_pop), .out_data (rsp_data)
   );
   assign rsp_empty = !ov;
endmodule
